### hw/rtl/irpd_pkg.sv
// shared types, constants and helpers of the ir pulse width frame decoder
`default_nettype none

package irpd_pkg;

  // depth of the aeha word store and width of the saturating word counter
  localparam int unsigned MAX_WORDS = 8;
  localparam int unsigned WC_W      = $clog2(MAX_WORDS + 1);

  // field widths
  localparam int unsigned PW_W    = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned BPOS_W  = 6;
  localparam int unsigned CIDX_W  = 4;
  localparam int unsigned OUT_DW  = 40;
  localparam int unsigned OUT_UW  = 3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_AEHA_LEADER_LIMIT = 4'd0;
  localparam logic [CIDX_W-1:0] REG_NEC_LEADER_LIMIT  = 4'd1;
  localparam logic [CIDX_W-1:0] REG_REPEAT_WIDTH      = 4'd2;
  localparam logic [CIDX_W-1:0] REG_REPEAT_WINDOW     = 4'd3;
  localparam logic [CIDX_W-1:0] REG_NEC_TURN          = 4'd4;
  localparam logic [CIDX_W-1:0] REG_NEC_HIGH          = 4'd5;
  localparam logic [CIDX_W-1:0] REG_AEHA_TURN         = 4'd6;
  localparam logic [CIDX_W-1:0] REG_AEHA_HIGH         = 4'd7;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NEC     = 2'd0,
    KIND_REPEAT  = 2'd1,
    KIND_AEHA    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  // frame decode phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  // thresholds handed from the register bank to the decoder
  typedef struct packed {
    logic [PW_W-1:0] aeha_leader_limit;
    logic [PW_W-1:0] nec_leader_limit;
    logic [PW_W-1:0] repeat_width;
    logic [PW_W-1:0] repeat_window;
    logic [PW_W-1:0] nec_turn;
    logic [PW_W-1:0] nec_high;
    logic [PW_W-1:0] aeha_turn;
    logic [PW_W-1:0] aeha_high;
  } cfg_t;

  // output byte order
  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/irpd_cfg_regs.sv
// threshold register bank of the ir pulse width frame decoder
`default_nettype none

module irpd_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [irpd_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [irpd_pkg::PW_W-1:0]   cfg_data,
  output irpd_pkg::cfg_t                   cfg_o
);

  irpd_pkg::cfg_t regs_r;
  irpd_pkg::cfg_t regs_nxt;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_o     = regs_r;

  // decode the register index, indexes beyond the bank are ignored
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        irpd_pkg::REG_AEHA_LEADER_LIMIT: regs_nxt.aeha_leader_limit = cfg_data;
        irpd_pkg::REG_NEC_LEADER_LIMIT:  regs_nxt.nec_leader_limit  = cfg_data;
        irpd_pkg::REG_REPEAT_WIDTH:      regs_nxt.repeat_width      = cfg_data;
        irpd_pkg::REG_REPEAT_WINDOW:     regs_nxt.repeat_window     = cfg_data;
        irpd_pkg::REG_NEC_TURN:          regs_nxt.nec_turn          = cfg_data;
        irpd_pkg::REG_NEC_HIGH:          regs_nxt.nec_high          = cfg_data;
        irpd_pkg::REG_AEHA_TURN:         regs_nxt.aeha_turn         = cfg_data;
        irpd_pkg::REG_AEHA_HIGH:         regs_nxt.aeha_high         = cfg_data;
        default:                         regs_nxt                   = regs_r;
      endcase
    end
  end

  // register bank with nominal timing defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.aeha_leader_limit <= 16'd1900;
      regs_r.nec_leader_limit  <= 16'd6500;
      regs_r.repeat_width      <= 16'd2250;
      regs_r.repeat_window     <= 16'd300;
      regs_r.nec_turn          <= 16'd200;
      regs_r.nec_high          <= 16'd1120;
      regs_r.aeha_turn         <= 16'd200;
      regs_r.aeha_high         <= 16'd850;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ir_pulse_width_frame_decoder_core.sv
// top level of the nec / aeha ir pulse width frame decoder
//
//  channel | dir | fields
//  --------+-----+---------------------------------------------------------
//  in_     | in  | tdata: pulse_width[15:0]; tuser: frame_start
//  out_    | out | tdata: word[31:0], word_index[34:32]; tuser: kind[1:0],
//          |     | overflow[2]; tlast: is_last
//  cfg_    | in  | cfg_index selects the threshold, cfg_data is its value
//
// one pulse width is taken per cycle while in_tready is high; a result shows on
// the out_ channel the cycle after the width that causes it, held in a single
// output register. in_tready drops only while that output register is full and
// not taken. rst_n is synchronous: it returns the decoder to idle and the
// thresholds to their nominal values. cfg_ready is always high.
`default_nettype none

module ir_pulse_width_frame_decoder_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // pulse width stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [15:0]                 in_tdata,   // pulse_width[15:0]
  input  wire logic                        in_tuser,   // frame_start
  // decoded word stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [irpd_pkg::OUT_DW-1:0]      out_tdata,  // word[31:0], word_index[34:32]
  output logic [irpd_pkg::OUT_UW-1:0]      out_tuser,  // kind[1:0], overflow[2]
  output logic                             out_tlast,
  // threshold writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [irpd_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [irpd_pkg::PW_W-1:0]   cfg_data
);

  irpd_pkg::cfg_t cfg;

  irpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // frame state
  irpd_pkg::phase_t                   phase_r, phase_nxt;
  logic                               is_aeha_r, is_aeha_nxt;
  logic [irpd_pkg::WORD_W-1:0]        acc_r, acc_nxt;
  logic [irpd_pkg::BPOS_W-1:0]        bpos_r, bpos_nxt;
  logic [irpd_pkg::WC_W-1:0]          wc_r, wc_nxt;
  logic                               dropped_r, dropped_nxt;

  // output register
  logic                               out_valid_r, out_valid_nxt;
  logic [irpd_pkg::WORD_W-1:0]        word_r, word_nxt;
  logic [irpd_pkg::IDX_W-1:0]         idx_r, idx_nxt;
  irpd_pkg::kind_t                    kind_r, kind_nxt;
  logic                               last_r, last_nxt;
  logic                               ovf_r, ovf_nxt;

  logic                               in_xfer;
  logic                               emit;
  logic [irpd_pkg::PW_W-1:0]          w;
  logic [irpd_pkg::PW_W-1:0]          rep_diff;
  logic [irpd_pkg::WORD_W-1:0]        acc_set;
  logic [irpd_pkg::BPOS_W-1:0]        bpos_inc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign w         = in_tdata;
  assign rep_diff  = w - cfg.repeat_width;
  assign bpos_inc  = bpos_r + 6'd1;

  // accumulator with the current bit position set by the width
  always_comb begin
    acc_set = acc_r;
    if (is_aeha_r) begin
      if (w > cfg.aeha_high) acc_set[bpos_r[4:0]] = 1'b1;
    end else begin
      if (w > cfg.nec_high) acc_set[bpos_r[4:0]] = 1'b1;
    end
  end

  // one decode step per transfer
  always_comb begin
    phase_nxt   = phase_r;
    is_aeha_nxt = is_aeha_r;
    acc_nxt     = acc_r;
    bpos_nxt    = bpos_r;
    wc_nxt      = wc_r;
    dropped_nxt = dropped_r;
    emit        = 1'b0;
    word_nxt    = '0;
    idx_nxt     = '0;
    kind_nxt    = irpd_pkg::KIND_NEC;
    last_nxt    = 1'b1;
    ovf_nxt     = 1'b0;
    if (in_tuser) begin
      // frame start drops anything in progress
      phase_nxt   = irpd_pkg::PH_LEADER;
      is_aeha_nxt = 1'b0;
      acc_nxt     = '0;
      bpos_nxt    = '0;
      wc_nxt      = '0;
      dropped_nxt = 1'b0;
    end else begin
      case (phase_r)
        irpd_pkg::PH_LEADER: begin
          if (w < cfg.aeha_leader_limit) begin
            is_aeha_nxt = 1'b1;
            phase_nxt   = irpd_pkg::PH_DATA;
          end else if (w < cfg.nec_leader_limit) begin
            if (w >= cfg.repeat_width && rep_diff < cfg.repeat_window) begin
              phase_nxt = irpd_pkg::PH_IDLE;
              emit      = 1'b1;
              word_nxt  = '1;
              kind_nxt  = irpd_pkg::KIND_REPEAT;
            end else begin
              is_aeha_nxt = 1'b0;
              phase_nxt   = irpd_pkg::PH_DATA;
            end
          end else begin
            phase_nxt = irpd_pkg::PH_IDLE;
            emit      = 1'b1;
            kind_nxt  = irpd_pkg::KIND_UNKNOWN;
          end
        end
        irpd_pkg::PH_DATA: begin
          if (!is_aeha_r) begin
            // nec: keep the first 32 bits only
            if (w <= cfg.nec_turn) begin
              phase_nxt = irpd_pkg::PH_IDLE;
              emit      = 1'b1;
              word_nxt  = irpd_pkg::swap_bytes(acc_r);
              kind_nxt  = irpd_pkg::KIND_NEC;
            end else if (!bpos_r[5]) begin
              acc_nxt  = acc_set;
              bpos_nxt = bpos_inc;
            end
          end else if (w <= cfg.aeha_turn) begin
            // aeha end of frame, end marker when past the store depth
            phase_nxt = irpd_pkg::PH_IDLE;
            emit      = 1'b1;
            kind_nxt  = irpd_pkg::KIND_AEHA;
            if (wc_r < irpd_pkg::WC_W'(irpd_pkg::MAX_WORDS)) begin
              word_nxt = irpd_pkg::swap_bytes(acc_r);
              idx_nxt  = irpd_pkg::IDX_W'(wc_r);
              ovf_nxt  = dropped_r;
            end else begin
              dropped_nxt = 1'b1;
              idx_nxt     = irpd_pkg::IDX_W'(irpd_pkg::MAX_WORDS - 1);
              ovf_nxt     = 1'b1;
            end
          end else begin
            // aeha data bit, a full word goes out at once
            acc_nxt  = acc_set;
            bpos_nxt = bpos_inc;
            if (bpos_inc[5]) begin
              acc_nxt  = '0;
              bpos_nxt = '0;
              if (wc_r < irpd_pkg::WC_W'(irpd_pkg::MAX_WORDS)) begin
                wc_nxt   = wc_r + irpd_pkg::WC_W'(1);
                emit     = 1'b1;
                word_nxt = irpd_pkg::swap_bytes(acc_set);
                idx_nxt  = irpd_pkg::IDX_W'(wc_r);
                kind_nxt = irpd_pkg::KIND_AEHA;
                last_nxt = 1'b0;
                ovf_nxt  = dropped_r;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // output register valid follows the transfer that fills it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= irpd_pkg::PH_IDLE;
      is_aeha_r   <= 1'b0;
      acc_r       <= '0;
      bpos_r      <= '0;
      wc_r        <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        phase_r   <= phase_nxt;
        is_aeha_r <= is_aeha_nxt;
        acc_r     <= acc_nxt;
        bpos_r    <= bpos_nxt;
        wc_r      <= wc_nxt;
        dropped_r <= dropped_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      word_r <= word_nxt;
      idx_r  <= idx_nxt;
      kind_r <= kind_nxt;
      last_r <= last_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, idx_r, word_r};
  assign out_tuser  = {ovf_r, kind_r};
  assign out_tlast  = last_r;

  // a repeat result is an all-ones single word frame
  a_repeat_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == irpd_pkg::KIND_REPEAT
      |-> word_r == '1 && last_r && idx_r == '0 && !ovf_r)
    else $error("repeat result malformed");

  // an unrecognized leader gives a zero word end marker
  a_unknown_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == irpd_pkg::KIND_UNKNOWN
      |-> word_r == '0 && last_r && !ovf_r)
    else $error("unrecognized result malformed");

  // nec data is always the last and only word of its frame
  a_nec_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == irpd_pkg::KIND_NEC |-> last_r && idx_r == '0 && !ovf_r)
    else $error("nec result malformed");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && !out_tready)
    else $error("input stalled without output back pressure");

  // word counter never runs past the store depth
  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= irpd_pkg::WC_W'(irpd_pkg::MAX_WORDS))
    else $error("word counter past store depth");

endmodule

`default_nettype wire

### sim/ir_pulse_width_frame_decoder_core_tb.sv
// self-checking testbench of the nec / aeha ir pulse width frame decoder core
`timescale 1ns / 100ps

module ir_pulse_width_frame_decoder_core_tb;
  import irpd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // one decoded word as it leaves the block
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  index;
    kind_t             kind;
    logic              is_last;
    logic              ovf;
  } word_result_t;

  // one row of the directed pulse table
  typedef struct {
    logic [PW_W-1:0] width;
    logic            start;
    bit              typed;
    bit              has_word;
    word_result_t    res;
  } pulse_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [15:0]         in_tdata;   // pulse_width[15:0]
  logic                in_tuser;   // frame_start
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;  // word[31:0], word_index[34:32], zero pad
  logic [OUT_UW-1:0]   out_tuser;  // kind[1:0], overflow[2]
  logic                out_tlast;  // is_last
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index;
  logic [PW_W-1:0]     cfg_data;

  // expected words in arrival order
  word_result_t pending_words[$];
  pulse_row_t   dir_rows[$];

  // decoder state and thresholds tracked by the testbench
  logic [PW_W-1:0]   thr [0:2**CIDX_W-1];
  phase_t            dec_phase = PH_IDLE;
  logic              dec_aeha  = 1'b0;
  logic [WORD_W-1:0] acc       = '0;
  logic [BPOS_W-1:0] bit_pos   = '0;
  logic [WC_W-1:0]   word_cnt  = '0;
  logic              dropped   = 1'b0;

  // directed rows carry their own expectation alongside the transfer
  logic         row_typed = 1'b0;
  logic         row_has   = 1'b0;
  word_result_t row_res   = '0;

  int mismatches  = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  bit hold_active = 1'b0;

  ir_pulse_width_frame_decoder_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // thresholds after reset
  initial begin
    thr[REG_AEHA_LEADER_LIMIT] = 16'd1900;
    thr[REG_NEC_LEADER_LIMIT]  = 16'd6500;
    thr[REG_REPEAT_WIDTH]      = 16'd2250;
    thr[REG_REPEAT_WINDOW]     = 16'd300;
    thr[REG_NEC_TURN]          = 16'd200;
    thr[REG_NEC_HIGH]          = 16'd1120;
    thr[REG_AEHA_TURN]         = 16'd200;
    thr[REG_AEHA_HIGH]         = 16'd850;
  end

  // advance the decoder by one pulse width, giving the word it emits if any
  task automatic decode_pulse(input logic [PW_W-1:0] w, input logic start,
                              output bit emitted, output word_result_t res);
    logic [WORD_W-1:0] full_word;
    emitted = 1'b0;
    res = '0;
    if (start) begin
      // a frame start drops whatever was in progress
      dec_aeha  = 1'b0;
      acc       = '0;
      bit_pos   = '0;
      word_cnt  = '0;
      dropped   = 1'b0;
      dec_phase = PH_LEADER;
    end else if (dec_phase == PH_LEADER) begin
      if (w < thr[REG_AEHA_LEADER_LIMIT]) begin
        dec_aeha  = 1'b1;
        dec_phase = PH_DATA;
      end else if (w < thr[REG_NEC_LEADER_LIMIT]) begin
        if (w >= thr[REG_REPEAT_WIDTH] &&
            (w - thr[REG_REPEAT_WIDTH]) < thr[REG_REPEAT_WINDOW]) begin
          dec_phase = PH_IDLE;
          emitted   = 1'b1;
          res       = '{32'hFFFF_FFFF, '0, KIND_REPEAT, 1'b1, 1'b0};
        end else begin
          dec_aeha  = 1'b0;
          dec_phase = PH_DATA;
        end
      end else begin
        dec_phase = PH_IDLE;
        emitted   = 1'b1;
        res       = '{'0, '0, KIND_UNKNOWN, 1'b1, 1'b0};
      end
    end else if (dec_phase == PH_DATA) begin
      if (!dec_aeha) begin
        // nec keeps the first 32 bits only
        if (w <= thr[REG_NEC_TURN]) begin
          dec_phase = PH_IDLE;
          emitted   = 1'b1;
          res       = '{swap_bytes(acc), '0, KIND_NEC, 1'b1, 1'b0};
        end else if (bit_pos < 32) begin
          if (w > thr[REG_NEC_HIGH]) acc[bit_pos[4:0]] = 1'b1;
          bit_pos++;
        end
      end else if (w <= thr[REG_AEHA_TURN]) begin
        // aeha final word, or an end marker once the store is full
        dec_phase = PH_IDLE;
        emitted   = 1'b1;
        if (word_cnt < MAX_WORDS) begin
          res = '{swap_bytes(acc), word_cnt[IDX_W-1:0], KIND_AEHA, 1'b1, dropped};
        end else begin
          dropped = 1'b1;
          res = '{'0, IDX_W'(MAX_WORDS - 1), KIND_AEHA, 1'b1, 1'b1};
        end
      end else begin
        if (w > thr[REG_AEHA_HIGH]) acc[bit_pos[4:0]] = 1'b1;
        bit_pos++;
        // every full 32 bits goes out at once while the store has room
        if (bit_pos >= 32) begin
          full_word = acc;
          acc       = '0;
          bit_pos   = '0;
          if (word_cnt < MAX_WORDS) begin
            emitted = 1'b1;
            res = '{swap_bytes(full_word), word_cnt[IDX_W-1:0], KIND_AEHA, 1'b0, dropped};
            word_cnt++;
          end else begin
            dropped = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(input string why, input word_result_t want,
                                 input word_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0d] %s: expected word=%h idx=%0d kind=%0d last=%b ovf=%b",
               cycle_count, why, want.word, want.index, want.kind, want.is_last,
               want.ovf);
    if (mismatches <= 10)
      $display("[%0d]   actual word=%h idx=%0d kind=%0d last=%b ovf=%b",
               cycle_count, got.word, got.index, got.kind, got.is_last, got.ovf);
  endtask

  // transfer monitor: tracks writes, predicts on input, checks on output
  always @(posedge clk) begin : monitor
    bit           made;
    word_result_t pred;
    word_result_t got;
    word_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_AEHA_HIGH)
        thr[cfg_index] = cfg_data;
      if (in_tvalid && in_tready) begin
        decode_pulse(in_tdata, in_tuser, made, pred);
        if (row_typed) begin
          if (row_has) pending_words.push_back(row_res);
        end else if (made) begin
          pending_words.push_back(pred);
        end
      end
      if (out_tvalid && out_tready) begin
        got.word    = out_tdata[WORD_W-1:0];
        got.index   = out_tdata[WORD_W+IDX_W-1:WORD_W];
        got.kind    = kind_t'(out_tuser[KIND_W-1:0]);
        got.is_last = out_tlast;
        got.ovf     = out_tuser[KIND_W];
        if (pending_words.size() == 0) begin
          report_mismatch("result with nothing pending", got, got);
        end else begin
          want = pending_words.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off, always ready at the end
  initial begin
    forever begin
      if (hold_req && !hold_done) begin
        out_tready  <= 1'b0;
        hold_active = 1'b1;
        repeat (400) @(posedge clk);
        hold_done   = 1'b1;
        hold_active = 1'b0;
      end else if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(3, 0) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end
    end
  end

  function automatic logic [PW_W-1:0] pick(input int lo, input int hi);
    if (hi > 65535) hi = 65535;
    if (lo > hi) return 16'($urandom);
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic cfg_t make_thresholds(
      input logic [PW_W-1:0] aeha_lim, nec_lim, rpt_w, rpt_win,
      input logic [PW_W-1:0] nec_t, nec_h, aeha_t, aeha_h);
    cfg_t c;
    c.aeha_leader_limit = aeha_lim;
    c.nec_leader_limit  = nec_lim;
    c.repeat_width      = rpt_w;
    c.repeat_window     = rpt_win;
    c.nec_turn          = nec_t;
    c.nec_high          = nec_h;
    c.aeha_turn         = aeha_t;
    c.aeha_high         = aeha_h;
    return c;
  endfunction

  // one pulse transfer, then possibly an idle burst
  task automatic send_item(input logic [PW_W-1:0] w, input logic start);
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (!quiet && !hold_active && $urandom_range(5, 0) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  task automatic send_pulse(input logic [PW_W-1:0] w, input logic start);
    row_typed <= 1'b0;
    send_item(w, start);
  endtask

  task automatic add_row(input logic [PW_W-1:0] w, input logic start, input bit typed,
                         input bit has_word, input logic [WORD_W-1:0] word,
                         input kind_t kind);
    pulse_row_t r;
    r.width    = w;
    r.start    = start;
    r.typed    = typed;
    r.has_word = has_word;
    r.res      = '{word, '0, kind, 1'b1, 1'b0};
    dir_rows.push_back(r);
  endtask

  // one frame shaped by the current thresholds; some noise and cut frames
  task automatic send_random_frame(input int forced_bits);
    int          lead_sel;
    int          nbits;
    int          len_sel;
    int          turn_lvl;
    int          high_lvl;
    int          lo;
    logic [PW_W-1:0] lead;
    bit          aeha;
    bit          rpt;
    if (forced_bits == 0 && $urandom_range(99, 0) < 6) begin
      send_pulse(16'($urandom), 1'($urandom));
      return;
    end
    send_pulse(16'($urandom), 1'b1);

    // leader aimed at one of the formats
    lead_sel = (forced_bits != 0) ? 0 : $urandom_range(9, 0);
    if (lead_sel < 4)
      lead = pick(0, int'(thr[REG_AEHA_LEADER_LIMIT]) - 1);
    else if (lead_sel < 7)
      lead = pick(int'(thr[REG_AEHA_LEADER_LIMIT]), int'(thr[REG_NEC_LEADER_LIMIT]) - 1);
    else if (lead_sel == 7)
      lead = pick(int'(thr[REG_REPEAT_WIDTH]),
                  int'(thr[REG_REPEAT_WIDTH]) + int'(thr[REG_REPEAT_WINDOW]) - 1);
    else if (lead_sel == 8)
      lead = pick(int'(thr[REG_NEC_LEADER_LIMIT]), 65535);
    else
      lead = 16'($urandom);
    send_pulse(lead, 1'b0);

    aeha = lead < thr[REG_AEHA_LEADER_LIMIT];
    rpt  = lead >= thr[REG_REPEAT_WIDTH] &&
           (lead - thr[REG_REPEAT_WIDTH]) < thr[REG_REPEAT_WINDOW];
    if (!aeha && (lead >= thr[REG_NEC_LEADER_LIMIT] || rpt)) return;

    turn_lvl = aeha ? int'(thr[REG_AEHA_TURN]) : int'(thr[REG_NEC_TURN]);
    high_lvl = aeha ? int'(thr[REG_AEHA_HIGH]) : int'(thr[REG_NEC_HIGH]);

    // frame length: empty, short, full words, and past 32 bits
    len_sel = $urandom_range(9, 0);
    if (forced_bits != 0) nbits = forced_bits;
    else if (len_sel == 0) nbits = 0;
    else if (len_sel < 5) nbits = $urandom_range(31, 1);
    else if (len_sel < 8) nbits = aeha ? 32 * $urandom_range(2, 1) : 32;
    else if (len_sel == 8) nbits = $urandom_range(70, 33);
    else nbits = $urandom_range(100, 1);
    if (turn_lvl >= 65535) nbits = 0;

    for (int b = 0; b < nbits; b++) begin
      if ($urandom_range(1, 0)) begin
        lo = (high_lvl > turn_lvl ? high_lvl : turn_lvl) + 1;
        if (lo > 65535) lo = turn_lvl + 1;
        send_pulse(pick(lo, 65535), 1'b0);
      end else begin
        send_pulse(pick(turn_lvl + 1, high_lvl > turn_lvl ? high_lvl : 65535), 1'b0);
      end
    end

    // a few frames are cut off and dropped by the next frame start
    if (forced_bits != 0 || $urandom_range(9, 0) != 0)
      send_pulse(pick(0, turn_lvl), 1'b0);
  endtask

  // wait until every expected word is out and the pipeline is quiet
  task automatic wait_idle();
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int n);
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < n) send_random_frame(0);
    in_tvalid <= 1'b0;
    wait_idle();
  endtask

  task automatic load_thresholds(input cfg_t c);
    logic [PW_W-1:0] vals [0:2**CIDX_W-1];
    int i;
    vals[REG_AEHA_LEADER_LIMIT] = c.aeha_leader_limit;
    vals[REG_NEC_LEADER_LIMIT]  = c.nec_leader_limit;
    vals[REG_REPEAT_WIDTH]      = c.repeat_width;
    vals[REG_REPEAT_WINDOW]     = c.repeat_window;
    vals[REG_NEC_TURN]          = c.nec_turn;
    vals[REG_NEC_HIGH]          = c.nec_high;
    vals[REG_AEHA_TURN]         = c.aeha_turn;
    vals[REG_AEHA_HIGH]         = c.aeha_high;
    for (i = 0; i <= int'(REG_AEHA_HIGH); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CIDX_W'(i);
      cfg_data  <= vals[CIDX_W'(i)];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    int a_lim;
    int r_w;
    int r_win;
    int n_lim;
    int n_t;
    int a_t;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_AEHA_LEADER_LIMIT;
    cfg_data  <= '0;
    rst_n     <= 1'b0;

    // directed table at reset thresholds
    add_row(16'hFFFF, 1'b1, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'hFFFF, 1'b0, 1'b1, 1'b1, '0, KIND_UNKNOWN);
    add_row(16'd0,    1'b0, 1'b1, 1'b0, '0, KIND_NEC);       // idle width, ignored
    add_row(16'd0,    1'b1, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd2250, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, KIND_REPEAT);
    add_row(16'd0,    1'b1, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd2549, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, KIND_REPEAT);
    add_row(16'd0,    1'b1, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd2550, 1'b0, 1'b0, 1'b0, '0, KIND_NEC);       // just past the window
    add_row(16'd0,    1'b0, 1'b1, 1'b1, '0, KIND_NEC);       // empty nec frame
    add_row(16'd0,    1'b1, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd2249, 1'b0, 1'b0, 1'b0, '0, KIND_NEC);       // below repeat width
    add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd1121, 1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd1120, 1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd201,  1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd200,  1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd0,    1'b1, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd0,    1'b0, 1'b0, 1'b0, '0, KIND_NEC);       // aeha leader
    add_row(16'd851,  1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd850,  1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'hFFFF, 1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd200,  1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd0,    1'b1, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd6500, 1'b0, 1'b1, 1'b1, '0, KIND_UNKNOWN);
    add_row(16'd0,    1'b1, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd6499, 1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd2000, 1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd0,    1'b1, 1'b0, 1'b0, '0, KIND_NEC);       // restart mid-frame
    add_row(16'd1899, 1'b0, 1'b0, 1'b0, '0, KIND_NEC);
    add_row(16'd0,    1'b0, 1'b0, 1'b0, '0, KIND_NEC);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row_typed <= dir_rows[i].typed;
      row_has   <= dir_rows[i].has_word;
      row_res   <= dir_rows[i].res;
      send_item(dir_rows[i].width, dir_rows[i].start);
    end
    in_tvalid <= 1'b0;
    wait_idle();

    // reset thresholds: one frame past the word store, long receiver hold-off
    hold_req = 1'b1;
    send_random_frame(32 * MAX_WORDS + 34);
    run_phase(10);

    // all thresholds at zero
    load_thresholds(make_thresholds(16'd0, 16'd0, 16'd0, 16'd0,
                                    16'd0, 16'd0, 16'd0, 16'd0));
    run_phase(8);

    // all thresholds at full scale
    load_thresholds(make_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    run_phase(8);

    // every leader below 65535 nec data, every nonzero width a one
    load_thresholds(make_thresholds(16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                                    16'd0, 16'd0, 16'd0, 16'd0));
    run_phase(10);

    // random ordered thresholds
    repeat (2) begin
      a_lim = $urandom_range(3000, 300);
      r_w   = a_lim + $urandom_range(2000, 0);
      r_win = $urandom_range(1000, 1);
      n_lim = r_w + r_win + $urandom_range(5000, 0);
      n_t   = $urandom_range(500, 0);
      a_t   = $urandom_range(500, 0);
      load_thresholds(make_thresholds(16'(a_lim), 16'(n_lim), 16'(r_w), 16'(r_win),
                                      16'(n_t), 16'(n_t + $urandom_range(2000, 0)),
                                      16'(a_t), 16'(a_t + $urandom_range(2000, 0))));
      run_phase(8);
    end

    // nominal thresholds again, no idling on either side
    quiet = 1'b1;
    load_thresholds(make_thresholds(16'd1900, 16'd6500, 16'd2250, 16'd300,
                                    16'd200, 16'd1120, 16'd200, 16'd850));
    run_phase(15);

    repeat (10) @(posedge clk);
    if (pending_words.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_words.size());
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/irpd_pkg.sv
hw/rtl/irpd_cfg_regs.sv
hw/rtl/ir_pulse_width_frame_decoder_core.sv
sim/ir_pulse_width_frame_decoder_core_tb.sv
